>>> rtl/smb_pkg.sv
// shared types, codes and constants of the soil moisture balance block
`timescale 1ns / 1ps
package smb_pkg;

   localparam int WATER_W = 24;
   localparam int FRAC_W  = 17;
   localparam int BETA_W  = 16;
   localparam int CSR_IDX_W = 3;

   localparam logic [FRAC_W-1:0] ONE_Q16 = 17'd65536;

   // 2^-(2^-i), i = 1..16, in Q0.16
   localparam logic [15:0] EXP2_NEG_TAB [16] = '{
      16'd46341, 16'd55109, 16'd60097, 16'd62757, 16'd64132, 16'd64830, 16'd65182,
      16'd65359, 16'd65447, 16'd65492, 16'd65514, 16'd65525, 16'd65530, 16'd65533,
      16'd65535, 16'd65535
   };

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_AREA_SOURCE = 3'd0,
      CSR_FIELD_CAP   = 3'd1,
      CSR_EVAP_LIMIT  = 3'd2,
      CSR_SHAPE_EXP   = 3'd3,
      CSR_INIT_SM     = 3'd4,
      CSR_FIXED_AREA  = 3'd5
   } csr_idx_type;

   typedef struct packed {
      logic                  area_source;
      logic [WATER_W-1:0]    field_capacity;
      logic [FRAC_W-1:0]     evap_limit_fraction;
      logic [BETA_W-1:0]     shape_exponent;
      logic [WATER_W-1:0]    initial_soil_moisture;
      logic [FRAC_W-1:0]     fixed_area_fraction;
   } cfg_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_DIV_SAVE,
      OP_EAC,
      OP_POW_INIT,
      OP_NORM,
      OP_SQ,
      OP_LOGMUL,
      OP_EXP,
      OP_POW_DONE,
      OP_IEFF,
      OP_BAL,
      OP_RECH
   } op_type;

   typedef struct packed {
      op_type     op;
      logic       div_e;
      logic [3:0] idx;
   } cmd_type;

   typedef struct packed {
      logic z_norm;
      logic pow_special;
   } sts_type;

endpackage

>>> rtl/smb_if.sv
// valid/ready channel interfaces for request and response beats
`timescale 1ns / 1ps
interface smb_req_if;
   logic        valid;
   logic        ready;
   logic [23:0] total_input;
   logic [23:0] potential_evap;
   logic [16:0] area_fraction;
   modport source (output valid, output total_input, output potential_evap,
                   output area_fraction, input ready);
   modport sink   (input valid, input total_input, input potential_evap,
                   input area_fraction, output ready);
endinterface

interface smb_rsp_if;
   logic        valid;
   logic        ready;
   logic [23:0] recharge;
   logic [23:0] actual_evap;
   logic [23:0] soil_moisture_out;
   modport source (output valid, output recharge, output actual_evap,
                   output soil_moisture_out, input ready);
   modport sink   (input valid, input recharge, input actual_evap,
                   input soil_moisture_out, output ready);
endinterface

>>> rtl/soil_moisture_balance_step.sv
// top level of the soil moisture balance step
//  channel | dir | fields                                        | handshake
//  req_ch  | in  | total_input, potential_evap, area_fraction    | valid/ready
//  rsp_ch  | out | recharge, actual_evap, soil_moisture_out      | valid/ready
//  csr_*   | in  | csr_index, csr_wdata                          | csr_we
// a result is computed by the shared restoring divider (two 16-step runs), a normalize
// stage of up to 15 shifts and the 16-step log2 and exp2 loops; when the moisture ratio
// is zero or one the power is set directly and the normalize and loop steps are skipped
// the next beat can be taken in the cycle after the result is loaded
// reset is synchronous; soil store clears and the first beat loads initial moisture
// a result waits in its output register; a new beat stalls only at its final step
`timescale 1ns / 1ps
module soil_moisture_balance_step (
   input  logic                          clock,
   input  logic                          reset,
   smb_req_if.sink                       req_ch,
   smb_rsp_if.source                     rsp_ch,
   input  logic                          csr_we,
   input  logic [smb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [23:0]                   csr_wdata
);
   import smb_pkg::*;

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;

   smb_csr u_csr (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .cfg(cfg)
   );

   smb_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_ch.valid), .req_ready(req_ch.ready),
      .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready), .sts(sts), .cmd(cmd)
   );

   smb_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts), .cfg(cfg),
      .req_total_input(req_ch.total_input),
      .req_potential_evap(req_ch.potential_evap),
      .req_area_fraction(req_ch.area_fraction),
      .rsp_recharge(rsp_ch.recharge),
      .rsp_actual_evap(rsp_ch.actual_evap),
      .rsp_soil_moisture_out(rsp_ch.soil_moisture_out)
   );
endmodule

>>> rtl/smb_csr.sv
// configuration register file
`timescale 1ns / 1ps
module smb_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [smb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [23:0]                   csr_wdata,
   output smb_pkg::cfg_type              cfg
);
   import smb_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_AREA_SOURCE: cfg_in.area_source = csr_wdata[0];
            CSR_FIELD_CAP:   cfg_in.field_capacity = csr_wdata;
            CSR_EVAP_LIMIT:  cfg_in.evap_limit_fraction = csr_wdata[16:0];
            CSR_SHAPE_EXP:   cfg_in.shape_exponent = csr_wdata[15:0];
            CSR_INIT_SM:     cfg_in.initial_soil_moisture = csr_wdata;
            CSR_FIXED_AREA:  cfg_in.fixed_area_fraction = csr_wdata[16:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.area_source           <= 1'b0;
         cfg_ff.field_capacity        <= 24'd51200;
         cfg_ff.evap_limit_fraction   <= 17'd32768;
         cfg_ff.shape_exponent        <= 16'd8192;
         cfg_ff.initial_soil_moisture <= 24'd0;
         cfg_ff.fixed_area_fraction   <= 17'd65536;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule

>>> rtl/smb_datapath.sv
// arithmetic datapath: divider, log2/exp2 power, balance and recharge
`timescale 1ns / 1ps
module smb_datapath (
   input  logic             clock,
   input  logic             reset,
   input  smb_pkg::cmd_type cmd,
   output smb_pkg::sts_type sts,
   input  smb_pkg::cfg_type cfg,
   input  logic [23:0]      req_total_input,
   input  logic [23:0]      req_potential_evap,
   input  logic [16:0]      req_area_fraction,
   output logic [23:0]      rsp_recharge,
   output logic [23:0]      rsp_actual_evap,
   output logic [23:0]      rsp_soil_moisture_out
);
   import smb_pkg::*;

   logic [23:0] store_ff, store_in;
   logic        first_ff, first_in;
   logic [23:0] sm_ff, sm_in, fc_ff, fc_in, in_ff, in_in, pet_ff, pet_in;
   logic [16:0] area_ff, area_in;
   logic [40:0] den_ff, den_in;
   logic [41:0] rem_ff, rem_in;
   logic [15:0] quo_ff, quo_in;
   logic        sat_ff, sat_in, dsel_ff, dsel_in;
   logic [16:0] r_ff, r_in, e_ff, e_in, p_ff, p_in, acc_ff, acc_in;
   logic [23:0] eac_ff, eac_in;
   logic [15:0] z_ff, z_in, frac_ff, frac_in, g_ff, g_in;
   logic [4:0]  n_ff, n_in;
   logic [8:0]  q_ff, q_in;
   logic [25:0] ieff_ff, ieff_in;
   logic [23:0] o_rech_ff, o_rech_in, o_eac_ff, o_eac_in, o_sm_ff, o_sm_in;

   logic [23:0] fc_eff, init_sm;
   logic [16:0] lp_eff, area_sel, area_eff;
   logic [40:0] den_prod, eac_prod, ieff_prod;
   logic [41:0] div_den, rem_sh, dvd_init, dvs_init;
   logic [31:0] sq_prod;
   logic [16:0] zsq;
   logic [20:0] mag;
   logic [36:0] log_prod;
   logic [24:0] t_val;
   logic [32:0] exp_prod;
   logic [26:0] d_val;
   logic [42:0] rech_prod;
   logic [26:0] rech_w;

   assign fc_eff   = (cfg.field_capacity == 24'd0) ? 24'd1 : cfg.field_capacity;
   assign lp_eff   = (cfg.evap_limit_fraction == 17'd0) ? 17'd1 :
                     ((cfg.evap_limit_fraction > ONE_Q16) ? ONE_Q16 : cfg.evap_limit_fraction);
   assign init_sm  = first_ff ? ((cfg.initial_soil_moisture <= fc_eff) ?
                     cfg.initial_soil_moisture : fc_eff) : store_ff;
   assign den_prod = 41'(fc_eff) * 41'(lp_eff);
   assign div_den  = dsel_ff ? {1'b0, den_ff} : {18'd0, fc_ff};
   assign rem_sh   = {rem_ff[40:0], 1'b0};
   assign dvd_init = cmd.div_e ? {2'd0, sm_ff, 16'd0} : {18'd0, sm_ff};
   assign dvs_init = cmd.div_e ? {1'b0, den_ff} : {18'd0, fc_ff};
   assign eac_prod = 41'(pet_ff) * 41'(e_ff);
   assign sq_prod  = 32'(z_ff) * 32'(z_ff);
   assign zsq      = sq_prod[31:15];
   // log2 magnitude (n+1) - frac, Q.16
   assign mag      = {5'(n_ff + 5'd1), 16'd0} - {5'd0, frac_ff};
   assign log_prod = 37'(mag) * 37'(cfg.shape_exponent);
   assign t_val    = log_prod[36:12];
   assign exp_prod = 33'(acc_ff) * 33'(EXP2_NEG_TAB[cmd.idx]);
   assign ieff_prod = 41'(in_ff) * 41'(p_ff);
   assign d_val    = {3'd0, sm_ff} + {3'd0, in_ff} - {1'b0, ieff_ff} - {3'd0, eac_ff};
   assign area_sel = cfg.area_source ? area_ff : cfg.fixed_area_fraction;
   assign area_eff = (area_sel > ONE_Q16) ? ONE_Q16 : area_sel;
   assign rech_prod = 43'(ieff_ff) * 43'(area_eff);
   assign rech_w   = rech_prod[42:16];

   assign sts.z_norm      = z_ff[15];
   assign sts.pow_special = (r_ff == 17'd0) || r_ff[16];

   always_comb begin
      store_in = store_ff;  first_in = first_ff;
      sm_in = sm_ff;  fc_in = fc_ff;  in_in = in_ff;  pet_in = pet_ff;  area_in = area_ff;
      den_in = den_ff;  rem_in = rem_ff;  quo_in = quo_ff;  sat_in = sat_ff;
      dsel_in = dsel_ff;  r_in = r_ff;  e_in = e_ff;  p_in = p_ff;  acc_in = acc_ff;
      eac_in = eac_ff;  z_in = z_ff;  frac_in = frac_ff;  g_in = g_ff;  n_in = n_ff;
      q_in = q_ff;  ieff_in = ieff_ff;
      o_rech_in = o_rech_ff;  o_eac_in = o_eac_ff;  o_sm_in = o_sm_ff;
      case (cmd.op)
         OP_LOAD: begin
            sm_in    = init_sm;
            first_in = 1'b0;
            fc_in    = fc_eff;
            den_in   = den_prod;
            in_in    = req_total_input;
            pet_in   = req_potential_evap;
            area_in  = req_area_fraction;
         end
         OP_DIV_INIT: begin
            rem_in  = dvd_init;
            sat_in  = dvd_init >= dvs_init;
            dsel_in = cmd.div_e;
            quo_in  = 16'd0;
         end
         OP_DIV_STEP: begin
            if (rem_sh >= div_den) begin
               rem_in = rem_sh - div_den;
               quo_in = {quo_ff[14:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quo_in = {quo_ff[14:0], 1'b0};
            end
         end
         OP_DIV_SAVE: begin
            if (dsel_ff) begin
               e_in = sat_ff ? ONE_Q16 : {1'b0, quo_ff};
            end else begin
               r_in = sat_ff ? ONE_Q16 : {1'b0, quo_ff};
            end
         end
         OP_EAC: eac_in = eac_prod[39:16];
         OP_POW_INIT: begin
            z_in    = r_ff[15:0];
            n_in    = 5'd0;
            frac_in = 16'd0;
            if (r_ff == 17'd0) begin
               p_in = (cfg.shape_exponent == 16'd0) ? ONE_Q16 : 17'd0;
            end else begin
               p_in = ONE_Q16;
            end
         end
         OP_NORM: begin
            z_in = {z_ff[14:0], 1'b0};
            n_in = n_ff + 5'd1;
         end
         OP_SQ: begin
            if (zsq[16]) begin
               z_in    = zsq[16:1];
               frac_in = {frac_ff[14:0], 1'b1};
            end else begin
               z_in    = zsq[15:0];
               frac_in = {frac_ff[14:0], 1'b0};
            end
         end
         OP_LOGMUL: begin
            q_in   = t_val[24:16];
            g_in   = t_val[15:0];
            acc_in = ONE_Q16;
         end
         OP_EXP: begin
            if (g_ff[15]) begin
               acc_in = exp_prod[32:16];
            end
            g_in = {g_ff[14:0], 1'b0};
         end
         OP_POW_DONE: p_in = (q_ff >= 9'd17) ? 17'd0 : (acc_ff >> q_ff[4:0]);
         OP_IEFF: ieff_in = {1'b0, ieff_prod[40:16]};
         OP_BAL: begin
            if (d_val[26]) begin
               // deficit empties the soil
               eac_in = sm_ff;
               sm_in  = 24'd0;
            end else if (d_val[25:0] <= {2'd0, fc_ff}) begin
               sm_in = d_val[23:0];
            end else begin
               ieff_in = ieff_ff + d_val[25:0] - {2'd0, fc_ff};
               sm_in   = fc_ff;
            end
         end
         OP_RECH: begin
            o_rech_in = (rech_w[26:24] != 3'd0) ? 24'hFFFFFF : rech_w[23:0];
            o_eac_in  = eac_ff;
            o_sm_in   = sm_ff;
            store_in  = sm_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         store_ff <= 24'd0;
         first_ff <= 1'b1;
      end else begin
         store_ff <= store_in;
         first_ff <= first_in;
      end
      sm_ff <= sm_in;  fc_ff <= fc_in;  in_ff <= in_in;  pet_ff <= pet_in;
      area_ff <= area_in;  den_ff <= den_in;  rem_ff <= rem_in;  quo_ff <= quo_in;
      sat_ff <= sat_in;  dsel_ff <= dsel_in;  r_ff <= r_in;  e_ff <= e_in;
      p_ff <= p_in;  acc_ff <= acc_in;  eac_ff <= eac_in;  z_ff <= z_in;
      frac_ff <= frac_in;  g_ff <= g_in;  n_ff <= n_in;  q_ff <= q_in;
      ieff_ff <= ieff_in;
      o_rech_ff <= o_rech_in;  o_eac_ff <= o_eac_in;  o_sm_ff <= o_sm_in;
   end

   assign rsp_recharge          = o_rech_ff;
   assign rsp_actual_evap       = o_eac_ff;
   assign rsp_soil_moisture_out = o_sm_ff;
endmodule

>>> rtl/smb_ctrl.sv
// sequencing state machine and channel handshake
`timescale 1ns / 1ps
module smb_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  smb_pkg::sts_type sts,
   output smb_pkg::cmd_type cmd
);
   import smb_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_RINIT, S_RDIV, S_RSAVE, S_EINIT, S_EDIV, S_ESAVE, S_EAC, S_PINIT,
      S_NORM, S_SQ, S_LOGM, S_EXP, S_PDONE, S_IEFF, S_BAL, S_FIN
   } state_type;

   state_type  state_ff;
   logic [3:0] cnt_ff;
   logic       ready_ff, valid_ff;
   logic       out_free;

   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      cmd.op    = OP_NONE;
      cmd.div_e = 1'b0;
      cmd.idx   = cnt_ff;
      case (state_ff)
         S_IDLE:  if (req_valid && ready_ff) cmd.op = OP_LOAD;
         S_RINIT: cmd.op = OP_DIV_INIT;
         S_RDIV:  cmd.op = OP_DIV_STEP;
         S_RSAVE: cmd.op = OP_DIV_SAVE;
         S_EINIT: begin
            cmd.op    = OP_DIV_INIT;
            cmd.div_e = 1'b1;
         end
         S_EDIV:  cmd.op = OP_DIV_STEP;
         S_ESAVE: cmd.op = OP_DIV_SAVE;
         S_EAC:   cmd.op = OP_EAC;
         S_PINIT: cmd.op = OP_POW_INIT;
         S_NORM:  if (!sts.z_norm) cmd.op = OP_NORM;
         S_SQ:    cmd.op = OP_SQ;
         S_LOGM:  cmd.op = OP_LOGMUL;
         S_EXP:   cmd.op = OP_EXP;
         S_PDONE: cmd.op = OP_POW_DONE;
         S_IEFF:  cmd.op = OP_IEFF;
         S_BAL:   cmd.op = OP_BAL;
         S_FIN:   if (out_free) cmd.op = OP_RECH;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= 4'd0;
         ready_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         // in the final state a taken result is replaced by the new one
         if (valid_ff && rsp_ready && (state_ff != S_FIN)) valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_valid && ready_ff) begin
                  ready_ff <= 1'b0;
                  state_ff <= S_RINIT;
               end else begin
                  ready_ff <= 1'b1;
               end
            end
            S_RINIT: begin
               cnt_ff   <= 4'd0;
               state_ff <= S_RDIV;
            end
            S_RDIV: begin
               cnt_ff <= cnt_ff + 4'd1;
               if (cnt_ff == 4'd15) state_ff <= S_RSAVE;
            end
            S_RSAVE: state_ff <= S_EINIT;
            S_EINIT: begin
               cnt_ff   <= 4'd0;
               state_ff <= S_EDIV;
            end
            S_EDIV: begin
               cnt_ff <= cnt_ff + 4'd1;
               if (cnt_ff == 4'd15) state_ff <= S_ESAVE;
            end
            S_ESAVE: state_ff <= S_EAC;
            S_EAC:   state_ff <= S_PINIT;
            // zero or full ratio has its power set directly
            S_PINIT: state_ff <= sts.pow_special ? S_IEFF : S_NORM;
            S_NORM: begin
               cnt_ff <= 4'd0;
               if (sts.z_norm) state_ff <= S_SQ;
            end
            S_SQ: begin
               cnt_ff <= cnt_ff + 4'd1;
               if (cnt_ff == 4'd15) state_ff <= S_LOGM;
            end
            S_LOGM: begin
               cnt_ff   <= 4'd0;
               state_ff <= S_EXP;
            end
            S_EXP: begin
               cnt_ff <= cnt_ff + 4'd1;
               if (cnt_ff == 4'd15) state_ff <= S_PDONE;
            end
            S_PDONE: state_ff <= S_IEFF;
            S_IEFF:  state_ff <= S_BAL;
            S_BAL:   state_ff <= S_FIN;
            S_FIN: begin
               if (out_free) begin
                  valid_ff <= 1'b1;
                  ready_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready = ready_ff;
   assign rsp_valid = valid_ff;
endmodule

>>> dv/soil_moisture_balance_step_chk.sv
// checker: watches both channels, predicts each soil moisture step and compares results
`timescale 1ns / 1ps
module soil_moisture_balance_step_chk (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [23:0]                   req_total_input,
   input  logic [23:0]                   req_potential_evap,
   input  logic [16:0]                   req_area_fraction,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [23:0]                   rsp_recharge,
   input  logic [23:0]                   rsp_actual_evap,
   input  logic [23:0]                   rsp_soil_moisture_out,
   input  logic                          csr_we,
   input  logic [smb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [23:0]                   csr_wdata,
   output int                            fail_count,
   output int                            pending_steps,
   output int                            steps_checked
);
   import smb_pkg::*;

   typedef struct packed {
      logic [23:0] recharge;
      logic [23:0] actual_evap;
      logic [23:0] soil_moisture;
   } balance_type;

   balance_type expected_balance [$];
   cfg_type     soil_cfg;
   logic [23:0] soil_level;
   logic        first_pending;

   assign pending_steps = expected_balance.size();

   function automatic logic [16:0] cap_one(logic [16:0] v);
      return (v > ONE_Q16) ? ONE_Q16 : v;
   endfunction

   // truncated fixed-point r^beta via log2 squaring and exp2 products
   function automatic logic [16:0] ratio_power(logic [16:0] ratio, logic [15:0] beta);
      logic [63:0] z, mag, t, acc;
      int          n;
      logic [15:0] fr;
      logic [15:0] g;
      logic [47:0] q;
      n = 0;
      fr = '0;
      if (ratio == 0) return (beta == 0) ? ONE_Q16 : 17'd0;
      if (ratio >= ONE_Q16) return ONE_Q16;
      z = ratio;
      while (z < 32768 && n < 16) begin
         z = z << 1;
         n++;
      end
      for (int i = 15; i >= 0; i--) begin
         z = (z * z) >> 15;
         if (z >= 65536) begin
            z = z >> 1;
            fr[i] = 1'b1;
         end
      end
      mag = (64'(n + 1) << 16) - 64'(fr);
      t = (mag * beta) >> 12;
      q = t[63:16];
      g = t[15:0];
      acc = 65536;
      for (int i = 0; i < 16; i++)
         if (g[15-i]) acc = (acc * EXP2_NEG_TAB[i]) >> 16;
      if (q >= 17) return '0;
      return 17'(acc >> q);
   endfunction

   function automatic balance_type predict_balance(logic [23:0] water_in, logic [23:0] pet,
                                                   logic [16:0] area_in);
      logic [63:0] fc, lp, sm, r, e, eac, ieff, area, rech;
      longint      d;
      balance_type res;
      fc = (soil_cfg.field_capacity == 0) ? 64'd1 : 64'(soil_cfg.field_capacity);
      lp = (soil_cfg.evap_limit_fraction == 0) ? 64'd1 :
           64'(cap_one(soil_cfg.evap_limit_fraction));
      if (first_pending) begin
         soil_level = (soil_cfg.initial_soil_moisture <= fc) ?
                      soil_cfg.initial_soil_moisture : 24'(fc);
         first_pending = 1'b0;
      end
      sm = soil_level;
      r = (sm << 16) / fc;
      if (r > 65536) r = 65536;
      e = (sm << 32) / (fc * lp);
      if (e > 65536) e = 65536;
      eac = (64'(pet) * e) >> 16;
      ieff = (64'(water_in) * ratio_power(17'(r), soil_cfg.shape_exponent)) >> 16;
      d = longint'(sm) + longint'(water_in) - longint'(ieff) - longint'(eac);
      if (d < 0) begin
         eac = sm;
         sm = 0;
      end else if (64'(d) <= fc) begin
         sm = 64'(d);
      end else begin
         ieff = ieff + 64'(d) - fc;
         sm = fc;
      end
      area = cap_one(soil_cfg.area_source ? area_in : soil_cfg.fixed_area_fraction);
      rech = (ieff * area) >> 16;
      if (rech > 64'hFFFFFF) rech = 64'hFFFFFF;
      soil_level = sm[23:0];
      res.recharge = rech[23:0];
      res.actual_evap = eac[23:0];
      res.soil_moisture = sm[23:0];
      return res;
   endfunction

   task automatic report_mismatch(string field, logic [23:0] got, logic [23:0] want);
      $display("mismatch at step %0d: %s got %0d expected %0d", steps_checked, field, got,
               want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      balance_type want;
      if (reset) begin
         soil_cfg.area_source <= 1'b0;
         soil_cfg.field_capacity <= 24'd51200;
         soil_cfg.evap_limit_fraction <= 17'd32768;
         soil_cfg.shape_exponent <= 16'd8192;
         soil_cfg.initial_soil_moisture <= '0;
         soil_cfg.fixed_area_fraction <= ONE_Q16;
         soil_level = '0;
         first_pending = 1'b1;
         fail_count = 0;
         steps_checked = 0;
         expected_balance.delete();
      end else begin
         if (csr_we) begin
            case (csr_idx_type'(csr_index))
               CSR_AREA_SOURCE: soil_cfg.area_source <= csr_wdata[0];
               CSR_FIELD_CAP:   soil_cfg.field_capacity <= csr_wdata;
               CSR_EVAP_LIMIT:  soil_cfg.evap_limit_fraction <= csr_wdata[16:0];
               CSR_SHAPE_EXP:   soil_cfg.shape_exponent <= csr_wdata[15:0];
               CSR_INIT_SM:     soil_cfg.initial_soil_moisture <= csr_wdata;
               CSR_FIXED_AREA:  soil_cfg.fixed_area_fraction <= csr_wdata[16:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            expected_balance.push_back(predict_balance(req_total_input, req_potential_evap,
                                                       req_area_fraction));
         if (rsp_valid && rsp_ready) begin
            if (expected_balance.size() == 0) begin
               $display("unexpected result beat");
               fail_count++;
            end else begin
               want = expected_balance.pop_front();
               if (rsp_recharge !== want.recharge)
                  report_mismatch("recharge", rsp_recharge, want.recharge);
               if (rsp_actual_evap !== want.actual_evap)
                  report_mismatch("actual_evap", rsp_actual_evap, want.actual_evap);
               if (rsp_soil_moisture_out !== want.soil_moisture)
                  report_mismatch("soil_moisture_out", rsp_soil_moisture_out,
                                  want.soil_moisture);
            end
            steps_checked++;
         end
      end
   end

endmodule

>>> dv/soil_moisture_balance_step_tb.sv
// testbench top: stimulus, idling, configuration phases and verdict
`timescale 1ns / 1ps
module soil_moisture_balance_step_tb;
   import smb_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [23:0] csr_wdata = '0;
   int fail_count, pending_steps, steps_checked;
   int send_idle_pct, recv_idle_pct;
   int hold_off_cycles;
   longint cycle_count;
   int beats_sent;

   smb_req_if req_ch ();
   smb_rsp_if rsp_ch ();

   soil_moisture_balance_step dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   soil_moisture_balance_step_chk chk (
      .clock(clock), .reset(reset),
      .req_valid(req_ch.valid), .req_ready(req_ch.ready),
      .req_total_input(req_ch.total_input), .req_potential_evap(req_ch.potential_evap),
      .req_area_fraction(req_ch.area_fraction),
      .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready),
      .rsp_recharge(rsp_ch.recharge), .rsp_actual_evap(rsp_ch.actual_evap),
      .rsp_soil_moisture_out(rsp_ch.soil_moisture_out),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending_steps(pending_steps),
      .steps_checked(steps_checked)
   );

   always #2 clock = ~clock;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.total_input = '0;
      req_ch.potential_evap = '0;
      req_ch.area_fraction = '0;
      rsp_ch.ready = 1'b0;
   end

   // receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_off_cycles <= hold_off_cycles - 1;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 2000000) begin
         $display("timeout waiting for results");
         $display("soil_moisture_balance_step_tb failed");
         $finish;
      end
   end

   // valid stays up after a beat is taken; idle cycles and drain() drop it
   task automatic send_step(logic [23:0] water_in, logic [23:0] pet, logic [16:0] area);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.total_input <= water_in;
      req_ch.potential_evap <= pet;
      req_ch.area_fraction <= area;
      do @(posedge clock); while (!req_ch.ready);
      beats_sent++;
   endtask

   task automatic write_reg(csr_idx_type idx, logic [23:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // wait for every result, then let the block settle before touching registers
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_steps != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic random_step();
      logic [23:0] w, p;
      logic [16:0] a;
      case ($urandom_range(3))
         0: w = 24'($urandom);
         1: w = 24'($urandom_range(25600));
         2: w = 24'($urandom_range(2560));
         default: w = '0;
      endcase
      p = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(2560));
      a = ($urandom_range(4) == 0) ? 17'($urandom) : 17'($urandom_range(65536));
      send_step(w, p, a);
   endtask

   task automatic random_config();
      write_reg(CSR_AREA_SOURCE, 24'($urandom_range(1)));
      case ($urandom_range(3))
         0: write_reg(CSR_FIELD_CAP, 24'd1);
         1: write_reg(CSR_FIELD_CAP, 24'hFFFFFF);
         default: write_reg(CSR_FIELD_CAP, 24'($urandom_range(256, 200000)));
      endcase
      case ($urandom_range(3))
         0: write_reg(CSR_EVAP_LIMIT, 24'd1);
         1: write_reg(CSR_EVAP_LIMIT, 24'd65536);
         default: write_reg(CSR_EVAP_LIMIT, 24'($urandom & 24'h1FFFF));
      endcase
      case ($urandom_range(3))
         0: write_reg(CSR_SHAPE_EXP, 24'd0);
         1: write_reg(CSR_SHAPE_EXP, 24'd65535);
         default: write_reg(CSR_SHAPE_EXP, 24'($urandom_range(1024, 20480)));
      endcase
      write_reg(CSR_INIT_SM, 24'($urandom));
      write_reg(CSR_FIXED_AREA, 24'($urandom & 24'h1FFFF));
   endtask

   initial begin
      send_idle_pct = 20;
      recv_idle_pct = 75;
      hold_off_cycles = 0;
      cycle_count = 0;
      beats_sent = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: initial load clamped to capacity, field extremes, wet and dry soil
      write_reg(CSR_INIT_SM, 24'hFFFFFF);
      send_step(24'd0, 24'd0, 17'd0);
      send_step(24'hFFFFFF, 24'hFFFFFF, 17'h1FFFF);
      send_step(24'd0, 24'hFFFFFF, 17'd65536);
      send_step(24'd0, 24'd0, 17'd0);
      send_step(24'd512, 24'd0, 17'd32768);
      send_step(24'd25600, 24'd256, 17'd65536);
      send_step(24'hFFFFFF, 24'd0, 17'd1);
      drain();
      write_reg(CSR_AREA_SOURCE, 24'd1);
      write_reg(CSR_FIELD_CAP, 24'd0);
      write_reg(CSR_EVAP_LIMIT, 24'd0);
      write_reg(CSR_SHAPE_EXP, 24'd0);
      write_reg(CSR_FIXED_AREA, 24'h1FFFF);
      send_step(24'd300, 24'd5, 17'h1FFFF);
      send_step(24'd0, 24'd0, 17'd65537);
      send_step(24'hFFFFFF, 24'd7, 17'd65536);
      drain();
      // store above capacity after lowering it, huge lp, steep beta
      write_reg(CSR_FIELD_CAP, 24'hFFFFFF);
      write_reg(CSR_EVAP_LIMIT, 24'h1FFFF);
      write_reg(CSR_SHAPE_EXP, 24'hFFFF);
      write_reg(CSR_AREA_SOURCE, 24'd0);
      write_reg(CSR_FIXED_AREA, 24'd0);
      send_step(24'hFFFFFF, 24'd0, 17'd0);
      send_step(24'h800000, 24'd100, 17'd0);
      drain();
      write_reg(CSR_FIELD_CAP, 24'd1000);
      write_reg(CSR_FIXED_AREA, 24'd65536);
      send_step(24'd10, 24'd3, 17'd0);
      send_step(24'd2000, 24'd0, 17'd0);
      send_step(24'd0, 24'd40, 17'd0);
      drain();

      for (int phase = 0; phase < 12; phase++) begin
         if (phase == 4) begin
            send_idle_pct = 75;
            recv_idle_pct = 20;
         end else if (phase == 8) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (phase == 2) hold_off_cycles = 1500;
         for (int k = 0; k < 100; k++) random_step();
         drain();
         random_config();
      end

      while (pending_steps != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("sent %0d steps over 12 register settings, checked %0d results",
               beats_sent, steps_checked);
      if (fail_count == 0) begin
         $display("soil_moisture_balance_step_tb passed");
      end else begin
         $display("soil_moisture_balance_step_tb failed");
      end
      $finish;
   end

endmodule
